// ----- rtl/core/akf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude Kalman filter package
// Shared constants, types and saturating helpers for the filter core.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 16;

    typedef logic signed [WordBits-1:0] t_word;

    localparam t_word WordMax = {1'b0, {(WordBits-1){1'b1}}};
    localparam t_word WordMin = {1'b1, {(WordBits-1){1'b0}}};

    localparam logic [1:0] CfgTimeStep  = 2'd0;
    localparam logic [1:0] CfgNoiseH    = 2'd1;
    localparam logic [1:0] CfgNoiseV    = 2'd2;
    localparam logic [1:0] CfgMeasNoise = 2'd3;

    // Arithmetic unit operation codes.
    typedef enum logic [1:0] {
        t_op_none,
        t_op_mul,
        t_op_div
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DT2, S_HDV, S_HA, S_VA, S_VVDT, S_INNER,
        S_PRED, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1,
        S_KY0, S_KY1, S_KHH, S_KHV, S_K1HH, S_K1HV,
        S_OUT
    } t_state;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WordBits:0] s;
        s = {a[WordBits-1], a} + {b[WordBits-1], b};
        if (s[WordBits] != s[WordBits-1]) begin
            return s[WordBits] ? WordMin : WordMax;
        end
        return s[WordBits-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WordBits:0] s;
        s = {a[WordBits-1], a} - {b[WordBits-1], b};
        if (s[WordBits] != s[WordBits-1]) begin
            return s[WordBits] ? WordMin : WordMax;
        end
        return s[WordBits-1:0];
    endfunction

endpackage

// ----- rtl/core/altitude_kalman_filter_2state_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-state altitude Kalman filter core
// Predicts height, velocity and covariance, then corrects them with an
// altitude measurement. Signed Q16.16 arithmetic saturates throughout.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_vertical_accel, i_altitude_meas
//  output    out        o_valid / i_stall    o_height_est, o_velocity_est
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// An item passes through seventeen sequencer steps, counting the idle state that
// accepts it and the output state, plus two divide waits, each of which forms 48
// quotient bits at one bit per cycle and then hands the quotient over.
// Reset is synchronous and active low; it restores the register defaults
// and the filter state. The block takes no new item until the previous
// result has been taken, and the result holds while i_stall is high.
module altitude_kalman_filter_2state_core import akf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [31:0] i_vertical_accel,
    input  logic signed [31:0] i_altitude_meas,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_height_est,
    output logic signed [31:0] o_velocity_est,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_dt;
    logic [30:0] r_qh, r_qv, r_r;

    // Filter state.
    t_word r_h, r_v, r_hh, r_hv, r_vh, r_vv;
    t_word n_h, n_v, n_hh, n_hv, n_vh, n_vv;

    // Item and scratch registers.
    t_word r_a, r_z, r_t0, r_t1, r_k0, r_k1, r_y, r_s;
    t_word n_a, n_z, n_t0, n_t1, n_k0, n_k1, n_y, n_s;

    t_op   op;
    t_word op_a, op_b, res;
    logic  busy;
    t_word dt;

    assign dt = t_word'({16'd0, r_dt});

    akf_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_res   (res),
        .o_busy  (busy)
    );

    // Each state issues at most one operation; a multiply result (res) is
    // folded in by the following state, a divide quotient once busy is low.
    always_comb begin
        n_state = r_state;
        n_h = r_h; n_v = r_v; n_hh = r_hh; n_hv = r_hv; n_vh = r_vh; n_vv = r_vv;
        n_a = r_a; n_z = r_z; n_t0 = r_t0; n_t1 = r_t1;
        n_k0 = r_k0; n_k1 = r_k1; n_y = r_y; n_s = r_s;
        op   = t_op_none;
        op_a = dt;
        op_b = dt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a = i_vertical_accel;
                    n_z = i_altitude_meas;
                    op  = t_op_mul;
                    n_state = S_DT2;
                end
            end
            S_DT2: begin
                // res = dt*dt; keep half of it.
                n_t0 = res >>> 1;
                op = t_op_mul; op_a = dt; op_b = r_v;
                n_state = S_HDV;
            end
            S_HDV: begin
                n_t1 = res;
                op = t_op_mul; op_a = r_t0; op_b = r_a;
                n_state = S_HA;
            end
            S_HA: begin
                n_h = sat_add(r_h, sat_add(r_t1, res));
                op = t_op_mul; op_a = dt; op_b = r_a;
                n_state = S_VA;
            end
            S_VA: begin
                n_v = sat_add(r_v, res);
                op = t_op_mul; op_a = r_vv; op_b = dt;
                n_state = S_VVDT;
            end
            S_VVDT: begin
                n_t0 = res;
                op = t_op_mul; op_a = sat_add(sat_add(r_vh, r_hv), res); op_b = dt;
                n_state = S_INNER;
            end
            S_INNER: begin
                n_hh = sat_add(r_hh, sat_add(res, t_word'({1'b0, r_qh})));
                n_hv = sat_add(r_hv, r_t0);
                n_vh = sat_add(r_vh, r_t0);
                n_vv = sat_add(r_vv, t_word'({1'b0, r_qv}));
                n_state = S_PRED;
            end
            S_PRED: begin
                n_s = sat_add(r_hh, t_word'({1'b0, r_r}));
                if (n_s == '0) n_s = t_word'(1);
                n_y = sat_sub(r_z, r_h);
                op = t_op_div; op_a = r_hh; op_b = n_s;
                n_state = S_DIV0;
            end
            S_DIV0: begin
                if (!busy) n_state = S_WAIT0;
            end
            S_WAIT0: begin
                n_k0 = res;
                op = t_op_div; op_a = r_vh; op_b = r_s;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                if (!busy) n_state = S_WAIT1;
            end
            S_WAIT1: begin
                n_k1 = res;
                op = t_op_mul; op_a = r_k0; op_b = r_y;
                n_state = S_KY0;
            end
            S_KY0: begin
                n_h = sat_add(r_h, res);
                op = t_op_mul; op_a = r_k1; op_b = r_y;
                n_state = S_KY1;
            end
            S_KY1: begin
                n_v = sat_add(r_v, res);
                op = t_op_mul; op_a = r_k0; op_b = r_hh;
                n_state = S_KHH;
            end
            S_KHH: begin
                n_t0 = res;
                op = t_op_mul; op_a = r_k0; op_b = r_hv;
                n_state = S_KHV;
            end
            S_KHV: begin
                n_t1 = res;
                op = t_op_mul; op_a = r_k1; op_b = r_hh;
                n_state = S_K1HH;
            end
            S_K1HH: begin
                n_vh = sat_sub(r_vh, res);
                op = t_op_mul; op_a = r_k1; op_b = r_hv;
                n_state = S_K1HV;
            end
            S_K1HV: begin
                n_vv = sat_sub(r_vv, res);
                n_hh = sat_sub(r_hh, r_t0);
                n_hv = sat_sub(r_hv, r_t1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dt <= 16'd1966;
            r_qh <= 31'd19661;
            r_qv <= 31'd19661;
            r_r  <= 31'd1310720;
            r_h  <= '0;
            r_v  <= '0;
            r_hh <= t_word'(131072);
            r_hv <= '0;
            r_vh <= '0;
            r_vv <= t_word'(131072);
        end else begin
            r_state <= n_state;
            r_h <= n_h; r_v <= n_v;
            r_hh <= n_hh; r_hv <= n_hv; r_vh <= n_vh; r_vv <= n_vv;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgTimeStep:  r_dt <= i_cfg_data[15:0];
                    CfgNoiseH:    r_qh <= i_cfg_data;
                    CfgNoiseV:    r_qv <= i_cfg_data;
                    CfgMeasNoise: r_r  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_a <= n_a; r_z <= n_z; r_t0 <= n_t0; r_t1 <= n_t1;
        r_k0 <= n_k0; r_k1 <= n_k1; r_y <= n_y; r_s <= n_s;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_height_est   = r_h;
    assign o_velocity_est = r_v;

endmodule

// ----- rtl/core/akf_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One signed fixed-point multiply (registered) and one restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module akf_arith import akf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_op   i_op,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_res,
    output logic  o_busy
);

    localparam int QBits = WordBits + FracBits;
    localparam int CntBits = $clog2(QBits + 1);

    logic [WordBits-1:0]   mag_a, mag_b;
    logic [2*WordBits-1:0] prod;
    logic [2*WordBits-1:0] prod_sh;
    t_word                 mul_res;

    logic [QBits-1:0]      r_num, n_num;
    logic [QBits-1:0]      r_quo, n_quo;
    logic [WordBits:0]     r_rem, n_rem;
    logic [WordBits-1:0]   r_den, n_den;
    logic                  r_neg, n_neg;
    logic [CntBits-1:0]    r_cnt, n_cnt;
    logic                  r_run, n_run;
    logic                  r_div, n_div;
    t_word                 r_res, n_res;
    logic [WordBits:0]     trial;
    t_word                 div_res;

    function automatic t_word finish(input logic neg, input logic [QBits-1:0] q_hi_free,
                                     input logic hi_nz);
        logic [WordBits-1:0] lo;
        lo = q_hi_free[WordBits-1:0];
        if (neg) begin
            if (hi_nz || lo > {1'b1, {(WordBits-1){1'b0}}}) return WordMin;
            return t_word'(-lo);
        end
        if (hi_nz || lo[WordBits-1]) return WordMax;
        return t_word'(lo);
    endfunction

    assign mag_a   = i_a[WordBits-1] ? -i_a : i_a;
    assign mag_b   = i_b[WordBits-1] ? -i_b : i_b;
    assign prod    = mag_a * mag_b;
    assign prod_sh = prod >> FracBits;
    assign mul_res = finish(i_a[WordBits-1] ^ i_b[WordBits-1],
                            {{FracBits{1'b0}}, prod_sh[WordBits-1:0]},
                            |prod_sh[2*WordBits-1:WordBits]);
    assign trial   = {r_rem[WordBits-1:0], r_num[QBits-1]} - {1'b0, r_den};
    assign div_res = finish(r_neg, r_quo, |r_quo[QBits-1:WordBits]);

    always_comb begin
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_neg = r_neg;
        n_cnt = r_cnt;
        n_run = r_run;
        n_div = r_div;
        n_res = r_res;
        if (r_run) begin
            n_num = r_num << 1;
            if (!trial[WordBits]) begin
                n_rem = trial;
                n_quo = {r_quo[QBits-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[WordBits-1:0], r_num[QBits-1]};
                n_quo = {r_quo[QBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntBits'(1)) begin
                n_run = 1'b0;
            end
        end else if (i_op == t_op_mul) begin
            n_res = mul_res;
            n_div = 1'b0;
        end else if (i_op == t_op_div) begin
            n_num = {mag_a, {FracBits{1'b0}}};
            n_den = mag_b;
            n_neg = i_a[WordBits-1] ^ i_b[WordBits-1];
            n_rem = '0;
            n_quo = '0;
            n_cnt = CntBits'(QBits);
            n_run = 1'b1;
            n_div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
            r_div <= 1'b0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
            r_div <= n_div;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    // The result of the most recent operation: the quotient stays visible
    // after a divide until the next multiply replaces it.
    assign o_busy = r_run;
    assign o_res  = r_div ? div_res : r_res;

endmodule

// ----- rtl/core/akf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the altitude filter core
// Watches the handshake ports of the core over time.
// ----------------------------------------------------------------------------
module akf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_height_est
);

    // An accepted item makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("not busy after accept");

    // A result is never shown while the input side is open.
    a_valid_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result while idle");

    // A stalled result stays.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_height_est))
        else $error("stalled result changed");

    // Taking the result reopens the input side.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_stall) else $error("input not reopened");

endmodule

bind altitude_kalman_filter_2state_core akf_checker u_akf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_height_est (o_height_est)
);

// ----- tb/altitude_kalman_filter_2state_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude Kalman filter core testbench
// Drives acceleration and altitude items into the filter core, predicts the
// corrected height and velocity with a local fixed-point filter model, and
// compares every result field by field. Configuration is rewritten between
// phases while the core is idle, covering the register extremes.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_2state_core_test;
    import akf_pkg::*;

    localparam longint SatMax = 64'sd2147483647;
    localparam longint SatMin = -64'sd2147483648;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic signed [31:0] accel;
        logic signed [31:0] alt;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] velocity;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_vertical_accel = '0;
    logic signed [31:0] i_altitude_meas = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_height_est;
    logic signed [31:0] o_velocity_est;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;

    altitude_kalman_filter_2state_core u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Filter model state and register copies.
    longint est_h, est_v, p_hh, p_hv, p_vh, p_vv;
    longint reg_dt, reg_qh, reg_qv, reg_r;

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int error_count = 0;
    int results_seen = 0;
    int samples_sent = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    function automatic longint clamp32(input longint x);
        return x > SatMax ? SatMax : (x < SatMin ? SatMin : x);
    endfunction

    // Products of two 32-bit values fit in 64 bits, so the shift is exact.
    // Truncation toward zero comes from shifting the magnitude.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0) return clamp32(-((-p) >>> 16));
        return clamp32(p >>> 16);
    endfunction

    // The shifted numerator needs 48 bits; a 64-bit signed divide truncates
    // toward zero as the core does.
    function automatic longint fx_div(input longint n, input longint d);
        return clamp32((n <<< 16) / d);
    endfunction

    function automatic longint s_add(input longint a, input longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint s_sub(input longint a, input longint b);
        return clamp32(a - b);
    endfunction

    task automatic filter_reset();
        reg_dt = 1966; reg_qh = 19661; reg_qv = 19661; reg_r = 1310720;
        est_h = 0; est_v = 0;
        p_hh = 131072; p_hv = 0; p_vh = 0; p_vv = 131072;
    endtask

    // One predict and correct step; returns the corrected estimate.
    function automatic t_estimate filter_step(input t_sample smp);
        longint a, z, half_dt2, vv_dt, inner, s, k0, k1, y, hh, hv, vh, vv;
        t_estimate e;
        a = smp.accel;
        z = smp.alt;
        half_dt2 = fx_mul(reg_dt, reg_dt) >>> 1;
        est_h = s_add(est_h, s_add(fx_mul(reg_dt, est_v), fx_mul(half_dt2, a)));
        est_v = s_add(est_v, fx_mul(reg_dt, a));
        vv_dt = fx_mul(p_vv, reg_dt);
        inner = s_add(s_add(p_vh, p_hv), vv_dt);
        p_hh = s_add(p_hh, s_add(fx_mul(inner, reg_dt), reg_qh));
        p_hv = s_add(p_hv, vv_dt);
        p_vh = s_add(p_vh, vv_dt);
        p_vv = s_add(p_vv, reg_qv);
        s = s_add(p_hh, reg_r);
        // A zero innovation variance falls back to the smallest positive value.
        if (s == 0) s = 1;
        k0 = fx_div(p_hh, s);
        k1 = fx_div(p_vh, s);
        y = s_sub(z, est_h);
        est_h = s_add(est_h, fx_mul(k0, y));
        est_v = s_add(est_v, fx_mul(k1, y));
        // The covariance update works from the values before correction.
        hh = p_hh; hv = p_hv; vh = p_vh; vv = p_vv;
        p_hh = s_sub(hh, fx_mul(k0, hh));
        p_hv = s_sub(hv, fx_mul(k0, hv));
        p_vh = s_sub(vh, fx_mul(k1, hh));
        p_vv = s_sub(vv, fx_mul(k1, hv));
        e.height = est_h[31:0];
        e.velocity = est_v[31:0];
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // Set when the item on the input ports was taken at the last rising edge.
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: sends queued items in bursts with random gaps. The payload
    // changes only at the falling edge and only once the previous item is taken.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !in_taken)) begin
            // Hold the current item unchanged.
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            t_sample smp;
            smp = pending_samples.pop_front();
            i_vertical_accel <= smp.accel;
            i_altitude_meas <= smp.alt;
            i_valid <= 1'b1;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver stall pattern: long stretches with no stall and bursty stalls.
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Monitor: predicts on accepted inputs and checks accepted outputs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                t_sample smp;
                smp.accel = i_vertical_accel;
                smp.alt = i_altitude_meas;
                expected_estimates.push_back(filter_step(smp));
                samples_sent++;
            end
            if (o_valid && !i_stall) begin
                t_estimate want;
                results_seen++;
                if (expected_estimates.size() == 0) begin
                    report_mismatch("unexpected result, height", o_height_est, 0);
                end else begin
                    want = expected_estimates.pop_front();
                    if (o_height_est !== want.height)
                        report_mismatch("height_est", o_height_est, want.height);
                    if (o_velocity_est !== want.velocity)
                        report_mismatch("velocity_est", o_velocity_est, want.velocity);
                end
            end
            // Watchdog on cycles with no acceptance on either channel.
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || stim_done
                || (pending_samples.size() == 0 && expected_estimates.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("altitude_kalman_filter_2state_core_test: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input longint value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[30:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgTimeStep:  reg_dt = value & 64'hFFFF;
            CfgNoiseH:    reg_qh = value & 64'h7FFF_FFFF;
            CfgNoiseV:    reg_qv = value & 64'h7FFF_FFFF;
            default:      reg_r  = value & 64'h7FFF_FFFF;
        endcase
    endtask

    // Waits until every queued item is sent and every result checked, then
    // lets the core finish any trailing work before a register write.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_samples.size() > 0 || i_valid || expected_estimates.size() > 0)
               && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // Altitude that tracks a smooth trajectory with noise, so the filter
    // settles and most steps exercise ordinary, unsaturated arithmetic.
    longint track_alt = 0;
    function automatic t_sample realistic_sample();
        t_sample smp;
        track_alt += $signed($urandom_range(0, 20000)) - 10000;
        smp.accel = $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
        smp.alt = 32'(track_alt + $signed($urandom_range(0, 65536)) - 32768);
        return smp;
    endfunction

    task automatic queue_random(input int count);
        t_sample smp;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7) smp = realistic_sample();
            else begin
                smp.accel = rand_word();
                smp.alt = rand_word();
            end
            pending_samples.push_back(smp);
        end
    endtask

    initial begin
        t_sample smp;
        filter_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: field extremes, a zero measurement, alternating signs.
        smp = '{32'sh0, 32'sh0};                     pending_samples.push_back(smp);
        smp = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF};     pending_samples.push_back(smp);
        smp = '{32'sh8000_0000, 32'sh8000_0000};     pending_samples.push_back(smp);
        smp = '{32'sh7FFF_FFFF, 32'sh8000_0000};     pending_samples.push_back(smp);
        smp = '{32'sh8000_0000, 32'sh7FFF_FFFF};     pending_samples.push_back(smp);
        smp = '{32'shFFFF_FFFF, 32'sh0000_0001};     pending_samples.push_back(smp);
        smp = '{32'sh0001_0000, 32'shFFFF_0000};     pending_samples.push_back(smp);
        smp = '{32'shAAAA_AAAA, 32'sh5555_5555};     pending_samples.push_back(smp);
        smp = '{32'sh5555_5555, 32'shAAAA_AAAA};     pending_samples.push_back(smp);
        drain();

        // Zero noise and a large negative covariance can drive the innovation
        // variance through zero and negative values.
        write_reg(CfgMeasNoise, 0);
        write_reg(CfgNoiseH, 0);
        write_reg(CfgNoiseV, 0);
        write_reg(CfgTimeStep, 1);
        for (int i = 0; i < 8; i++) begin
            smp.accel = rand_word(); smp.alt = rand_word();
            pending_samples.push_back(smp);
        end
        drain();

        // Register extremes.
        write_reg(CfgTimeStep, 65535);
        write_reg(CfgNoiseH, 64'h7FFF_FFFF);
        write_reg(CfgNoiseV, 64'h7FFF_FFFF);
        write_reg(CfgMeasNoise, 64'h7FFF_FFFF);
        queue_random(8);
        drain();

        // Random phases with random settings, the defaults included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CfgTimeStep, 1966);
                    write_reg(CfgNoiseH, 19661);
                    write_reg(CfgNoiseV, 19661);
                    write_reg(CfgMeasNoise, 1310720);
                end
                default: begin
                    write_reg(CfgTimeStep, $urandom_range(1, 65535));
                    write_reg(CfgNoiseH, ($urandom_range(0, 1)) ? $urandom_range(0, 200000)
                                                                : {1'b0, $urandom} >> 1);
                    write_reg(CfgNoiseV, ($urandom_range(0, 1)) ? $urandom_range(0, 200000)
                                                                : {1'b0, $urandom} >> 1);
                    write_reg(CfgMeasNoise, ($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 3) : {1'b0, $urandom} >> 1);
                end
            endcase
            track_alt = 0;
            queue_random(155);
            drain();
        end

        stim_done = 1'b1;
        $display("covered %0d items and %0d results over nine register settings",
                 samples_sent, results_seen);
        $display("settings included zero noise, unit and full-scale time steps");
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("altitude_kalman_filter_2state_core_test: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_estimates.size());
            $display("altitude_kalman_filter_2state_core_test: done, errors");
        end
        $finish;
    end

endmodule
